// File: hdl/hash_group_by_file_stats_assert.svh
// Assertion macros for the group-by aggregation table.
// Used by hgbfs_back; expects signals named clock and reset in scope.
`ifndef HASH_GROUP_BY_FILE_STATS_ASSERT_SVH
`define HASH_GROUP_BY_FILE_STATS_ASSERT_SVH

`define HGBFS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hgbfs assertion failed");

`define HGBFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hgbfs assertion failed");

`endif

// File: hdl/hgbfs_pkg.sv
// Shared types and constants of the group-by aggregation table.
// No dependencies; used by every other file of the block except the assertion header.
`default_nettype none

package hgbfs_pkg;

   localparam int KEY_W  = 32;
   localparam int ID_W   = 32;
   localparam int SIZE_W = 48;
   localparam int BLK_W  = 40;
   localparam int TIME_W = 40;
   localparam int SEL_W  = 4;
   localparam int RB_W   = 10;
   localparam int BKT_W  = 11;
   localparam int TU_W   = 11;
   localparam int EXT_W  = 48;
   localparam int SUM_W  = 64;
   localparam int CNT_W  = 32;

   localparam logic [TU_W-1:0] TU_RESET = 11'd1024;

   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   localparam logic [1:0] STAT_NEW  = 2'd0;
   localparam logic [1:0] STAT_UPD  = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;
   localparam logic [1:0] STAT_READ = 2'd3;

   localparam logic [SEL_W-1:0] SEL_COUNT     = 4'd0;
   localparam logic [SEL_W-1:0] SEL_SUM_FIRST = 4'd1;
   localparam logic [SEL_W-1:0] SEL_SUM_LAST  = 4'd4;
   localparam logic [SEL_W-1:0] SEL_EXT_FIRST = 4'd5;
   localparam logic [SEL_W-1:0] SEL_EXT_LAST  = 4'd12;

   typedef struct packed {
      logic              kind;
      logic [KEY_W-1:0]  type_key;
      logic [ID_W-1:0]   file_id;
      logic [SIZE_W-1:0] file_size;
      logic [BLK_W-1:0]  block_count;
      logic [TIME_W-1:0] change_time;
      logic [TIME_W-1:0] modify_time;
      logic [BKT_W-1:0]  bucket;
      logic              rd_ok;
      logic [SEL_W-1:0]  stat_select;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0]            count;
      logic [3:0][SUM_W-1:0]       sums;
      logic [7:0][EXT_W-1:0]       ext;
      logic [7:0][ID_W-1:0]        ids;
   } group_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   function automatic logic [TU_W-1:0] buckets_in_use(input logic [TU_W-1:0] tu,
                                                      input int unsigned depth);
      logic [TU_W-1:0] n;
      n = tu;
      if (tu < 11'd2) begin
         n = 11'd2;
      end else if (32'(tu) > depth) begin
         n = TU_W'(depth);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// File: hdl/hgbfs_if.sv
// Request and response channel interfaces of the group-by aggregation table.
// Depends on hgbfs_pkg for field widths.
`default_nettype none

interface hgbfs_req_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic [hgbfs_pkg::KEY_W-1:0]        type_key;
   logic [hgbfs_pkg::ID_W-1:0]         file_id;
   logic [hgbfs_pkg::SIZE_W-1:0]       file_size;
   logic [hgbfs_pkg::BLK_W-1:0]        block_count;
   logic [hgbfs_pkg::TIME_W-1:0]       change_time;
   logic [hgbfs_pkg::TIME_W-1:0]       modify_time;
   logic [hgbfs_pkg::RB_W-1:0]         read_bucket;
   logic [hgbfs_pkg::SEL_W-1:0]        stat_select;

   modport source (output valid, kind, type_key, file_id, file_size, block_count,
                   change_time, modify_time, read_bucket, stat_select,
                   input ready);
   modport sink (input valid, kind, type_key, file_id, file_size, block_count,
                 change_time, modify_time, read_bucket, stat_select,
                 output ready);
endinterface

interface hgbfs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [hgbfs_pkg::RB_W-1:0]    bucket;
   logic                          occupied;
   logic [hgbfs_pkg::KEY_W-1:0]   entry_key;
   logic [hgbfs_pkg::SUM_W-1:0]   stat_value;
   logic [hgbfs_pkg::ID_W-1:0]    stat_file_id;

   modport source (output valid, status, bucket, occupied, entry_key, stat_value,
                   stat_file_id, input ready);
   modport sink (input valid, status, bucket, occupied, entry_key, stat_value,
                 stat_file_id, output ready);
endinterface

`default_nettype wire

// File: hdl/hgbfs_front.sv
// Front end: accepts requests and works out the home bucket of records.
// Home bucket comes from a radix-16 remainder unit. Depends on hgbfs_pkg, hgbfs_if.
`default_nettype none

module hgbfs_front #(
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   hgbfs_req_if.sink                           req,
   input  wire logic [hgbfs_pkg::TU_W-1:0]     table_used,
   input  wire hgbfs_pkg::back_status_type     back_status,
   output      logic                           push_valid,
   input  wire logic                           push_ready,
   output      hgbfs_pkg::cmd_type             push_data
);

   typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_type;

   front_state_type                   state_ff;
   hgbfs_pkg::cmd_type                cmd_ff;
   logic [hgbfs_pkg::TU_W-1:0]        n_ff;
   logic [hgbfs_pkg::TU_W-1:0]        rem_ff;
   logic [hgbfs_pkg::KEY_W-1:0]       key_sh_ff;
   logic [2:0]                        step_ff;
   logic [hgbfs_pkg::TU_W-1:0]        rem_in;
   logic [hgbfs_pkg::TU_W:0]          trial;

   assign req.ready  = (state_ff == F_IDLE) && !back_status.clearing;
   assign push_valid = (state_ff == F_PUSH);
   assign push_data  = cmd_ff;

   always_comb begin
      rem_in = rem_ff;
      trial  = '0;
      for (int i = 0; i < 4; i++) begin
         trial = {rem_in, key_sh_ff[hgbfs_pkg::KEY_W-1-i]};
         if (trial >= {1'b0, n_ff}) begin
            trial = trial - {1'b0, n_ff};
         end
         rem_in = trial[hgbfs_pkg::TU_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req.valid && req.ready) begin
                  cmd_ff.kind        <= req.kind;
                  cmd_ff.type_key    <= req.type_key;
                  cmd_ff.file_id     <= req.file_id;
                  cmd_ff.file_size   <= req.file_size;
                  cmd_ff.block_count <= req.block_count;
                  cmd_ff.change_time <= req.change_time;
                  cmd_ff.modify_time <= req.modify_time;
                  cmd_ff.stat_select <= req.stat_select;
                  cmd_ff.rd_ok       <= 32'(req.read_bucket) < TABLE_DEPTH;
                  cmd_ff.bucket      <= hgbfs_pkg::BKT_W'(req.read_bucket);
                  n_ff      <= hgbfs_pkg::buckets_in_use(table_used, TABLE_DEPTH);
                  rem_ff    <= '0;
                  key_sh_ff <= req.type_key;
                  step_ff   <= '0;
                  state_ff  <= (req.kind == hgbfs_pkg::KIND_READ) ? F_PUSH : F_DIV;
               end
            end
            F_DIV: begin
               rem_ff    <= rem_in;
               key_sh_ff <= key_sh_ff << 4;
               step_ff   <= step_ff + 3'd1;
               if (step_ff == 3'd7) begin
                  cmd_ff.bucket <= rem_in;
                  state_ff      <= F_PUSH;
               end
            end
            F_PUSH: begin
               if (push_ready) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: hdl/hgbfs_queue.sv
// Two-entry command queue between the front end and the table engine.
// Depends on hgbfs_pkg.
`default_nettype none

module hgbfs_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output      logic                in_ready,
   input  wire hgbfs_pkg::cmd_type  in_data,
   output      logic                out_valid,
   input  wire logic                out_ready,
   output      hgbfs_pkg::cmd_type  out_data
);

   hgbfs_pkg::cmd_type  slot_ff [2];
   logic                wr_ptr_ff;
   logic                rd_ptr_ff;
   logic [1:0]          cnt_ff;
   logic                push;
   logic                pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: hdl/hgbfs_back.sv
// Table engine: clears the bucket table, probes linearly, updates groups and
// answers reads. Holds the bucket and group memories. Depends on hgbfs_pkg, hgbfs_if and the assertion header.
`default_nettype none
`include "hash_group_by_file_stats_assert.svh"

module hgbfs_back #(
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [hgbfs_pkg::TU_W-1:0]     table_used,
   input  wire logic                           q_valid,
   output      logic                           q_ready,
   input  wire hgbfs_pkg::cmd_type             q_data,
   output      hgbfs_pkg::back_status_type     back_status,
   hgbfs_rsp_if.source                         rsp
);

   localparam int IW = $clog2(TABLE_DEPTH);

   typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_LOOK, B_CHECK} back_state_type;

   back_state_type                     state_ff;
   logic [IW-1:0]                      clr_addr_ff;
   hgbfs_pkg::cmd_type                 cmd_ff;
   logic [IW-1:0]                      b_ff;
   logic [hgbfs_pkg::TU_W-1:0]         coll_ff;
   logic [hgbfs_pkg::KEY_W-1:0]        home_key_ff;

   logic                               rsp_valid_ff;
   logic [1:0]                         rsp_status_ff;
   logic [hgbfs_pkg::RB_W-1:0]         rsp_bucket_ff;
   logic                               rsp_occupied_ff;
   logic [hgbfs_pkg::KEY_W-1:0]        rsp_key_ff;
   logic [hgbfs_pkg::SUM_W-1:0]        rsp_value_ff;
   logic [hgbfs_pkg::ID_W-1:0]         rsp_fid_ff;

   logic [hgbfs_pkg::KEY_W:0]          bkt_mem [TABLE_DEPTH];
   hgbfs_pkg::group_type               grp_mem [TABLE_DEPTH];
   logic [hgbfs_pkg::KEY_W:0]          bkt_rd_ff;
   hgbfs_pkg::group_type               grp_rd_ff;

   logic                               bkt_we;
   logic [IW-1:0]                      bkt_wa;
   logic [hgbfs_pkg::KEY_W:0]          bkt_wd;
   logic                               grp_we;
   hgbfs_pkg::group_type               grp_wd;

   logic [hgbfs_pkg::TU_W-1:0]         n_eff;
   logic                               occ;
   logic [hgbfs_pkg::KEY_W-1:0]        key;
   logic                               is_free;
   logic                               is_match;
   logic [hgbfs_pkg::TU_W-1:0]         coll_in;
   logic                               is_full;
   logic [IW-1:0]                      b_in;
   logic [7:0][hgbfs_pkg::EXT_W-1:0]   v;
   hgbfs_pkg::group_type               grp_new;
   hgbfs_pkg::group_type               grp_upd;
   logic                               take;
   logic                               rd_hit;
   logic [hgbfs_pkg::SUM_W-1:0]        rd_value;
   logic [hgbfs_pkg::ID_W-1:0]         rd_fid;
   logic                               in_check_rec;
   logic                               in_check_read;

   assign back_status.clearing = (state_ff == B_CLEAR);
   assign q_ready = (state_ff == B_IDLE) && (!rsp_valid_ff || rsp.ready);

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.bucket       = rsp_bucket_ff;
   assign rsp.occupied     = rsp_occupied_ff;
   assign rsp.entry_key    = rsp_key_ff;
   assign rsp.stat_value   = rsp_value_ff;
   assign rsp.stat_file_id = rsp_fid_ff;

   assign n_eff    = hgbfs_pkg::buckets_in_use(table_used, TABLE_DEPTH);
   assign occ      = bkt_rd_ff[hgbfs_pkg::KEY_W];
   assign key      = bkt_rd_ff[hgbfs_pkg::KEY_W-1:0];
   assign is_free  = !occ;
   assign is_match = occ && (key == cmd_ff.type_key);
   assign coll_in  = coll_ff + 11'd1;
   assign is_full  = (coll_in == n_eff - 11'd1);
   assign b_in     = (32'(b_ff) + 32'd1 < 32'(n_eff)) ? b_ff + IW'(1) : '0;
   assign rd_hit   = cmd_ff.rd_ok && occ;
   assign in_check_rec = (state_ff == B_CHECK) && (cmd_ff.kind == hgbfs_pkg::KIND_RECORD);
   assign in_check_read = (state_ff == B_CHECK) && (cmd_ff.kind == hgbfs_pkg::KIND_READ);

   always_comb begin
      v[0] = hgbfs_pkg::EXT_W'(cmd_ff.change_time);
      v[1] = hgbfs_pkg::EXT_W'(cmd_ff.change_time);
      v[2] = hgbfs_pkg::EXT_W'(cmd_ff.modify_time);
      v[3] = hgbfs_pkg::EXT_W'(cmd_ff.modify_time);
      v[4] = cmd_ff.file_size;
      v[5] = cmd_ff.file_size;
      v[6] = hgbfs_pkg::EXT_W'(cmd_ff.block_count);
      v[7] = hgbfs_pkg::EXT_W'(cmd_ff.block_count);
   end

   always_comb begin
      take = 1'b0;
      grp_new.count   = 32'd1;
      grp_new.sums[0] = hgbfs_pkg::SUM_W'(cmd_ff.file_size);
      grp_new.sums[1] = hgbfs_pkg::SUM_W'(cmd_ff.block_count);
      grp_new.sums[2] = hgbfs_pkg::SUM_W'(cmd_ff.change_time);
      grp_new.sums[3] = hgbfs_pkg::SUM_W'(cmd_ff.modify_time);
      grp_new.ext     = v;
      for (int i = 0; i < 8; i++) begin
         grp_new.ids[i] = cmd_ff.file_id;
      end
      grp_upd = grp_rd_ff;
      if (grp_rd_ff.count != 32'hFFFF_FFFF) begin
         grp_upd.count = grp_rd_ff.count + 32'd1;
      end
      grp_upd.sums[0] = grp_rd_ff.sums[0] + hgbfs_pkg::SUM_W'(cmd_ff.file_size);
      grp_upd.sums[1] = grp_rd_ff.sums[1] + hgbfs_pkg::SUM_W'(cmd_ff.block_count);
      grp_upd.sums[2] = grp_rd_ff.sums[2] + hgbfs_pkg::SUM_W'(cmd_ff.change_time);
      grp_upd.sums[3] = grp_rd_ff.sums[3] + hgbfs_pkg::SUM_W'(cmd_ff.modify_time);
      for (int i = 0; i < 8; i++) begin
         take = i[0] ? (v[i] > grp_rd_ff.ext[i]) : (v[i] < grp_rd_ff.ext[i]);
         if (take) begin
            grp_upd.ext[i] = v[i];
            grp_upd.ids[i] = cmd_ff.file_id;
         end
      end
   end

   always_comb begin
      rd_value = '0;
      rd_fid   = '0;
      if (rd_hit) begin
         unique case (cmd_ff.stat_select) inside
            hgbfs_pkg::SEL_COUNT: begin
               rd_value = hgbfs_pkg::SUM_W'(grp_rd_ff.count);
            end
            [hgbfs_pkg::SEL_SUM_FIRST:hgbfs_pkg::SEL_SUM_LAST]: begin
               rd_value = grp_rd_ff.sums[2'(cmd_ff.stat_select - hgbfs_pkg::SEL_SUM_FIRST)];
            end
            [hgbfs_pkg::SEL_EXT_FIRST:hgbfs_pkg::SEL_EXT_LAST]: begin
               rd_value = hgbfs_pkg::SUM_W'(
                  grp_rd_ff.ext[3'(cmd_ff.stat_select - hgbfs_pkg::SEL_EXT_FIRST)]);
               rd_fid = grp_rd_ff.ids[3'(cmd_ff.stat_select - hgbfs_pkg::SEL_EXT_FIRST)];
            end
            default: begin
               rd_value = '0;
               rd_fid   = '0;
            end
         endcase
      end
   end

   always_comb begin
      bkt_we = 1'b0;
      bkt_wa = b_ff;
      bkt_wd = {1'b1, cmd_ff.type_key};
      grp_we = 1'b0;
      grp_wd = grp_upd;
      if (state_ff == B_CLEAR) begin
         bkt_we = 1'b1;
         bkt_wa = clr_addr_ff;
         bkt_wd = '0;
      end else if (in_check_rec) begin
         if (is_free) begin
            bkt_we = 1'b1;
            grp_we = 1'b1;
            grp_wd = grp_new;
         end else if (is_match) begin
            grp_we = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bkt_mem[bkt_wa] <= bkt_wd;
      end
      bkt_rd_ff <= bkt_mem[b_ff];
   end

   always_ff @(posedge clock) begin
      if (grp_we) begin
         grp_mem[b_ff] <= grp_wd;
      end
      grp_rd_ff <= grp_mem[b_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + IW'(1);
               if (clr_addr_ff == IW'(TABLE_DEPTH - 1)) begin
                  state_ff <= B_IDLE;
               end
            end
            B_IDLE: begin
               if (q_valid && q_ready) begin
                  cmd_ff   <= q_data;
                  b_ff     <= IW'(q_data.bucket);
                  coll_ff  <= '0;
                  state_ff <= B_LOOK;
               end
            end
            B_LOOK: begin
               state_ff <= B_CHECK;
            end
            B_CHECK: begin
               if (coll_ff == '0) begin
                  home_key_ff <= key;
               end
               if (cmd_ff.kind == hgbfs_pkg::KIND_READ) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_status_ff   <= hgbfs_pkg::STAT_READ;
                  rsp_bucket_ff   <= hgbfs_pkg::RB_W'(cmd_ff.bucket);
                  rsp_occupied_ff <= rd_hit;
                  rsp_key_ff      <= rd_hit ? key : '0;
                  rsp_value_ff    <= rd_value;
                  rsp_fid_ff      <= rd_fid;
                  state_ff        <= B_IDLE;
               end else if (is_free || is_match) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_status_ff   <= is_free ? hgbfs_pkg::STAT_NEW : hgbfs_pkg::STAT_UPD;
                  rsp_bucket_ff   <= hgbfs_pkg::RB_W'(b_ff);
                  rsp_occupied_ff <= 1'b1;
                  rsp_key_ff      <= cmd_ff.type_key;
                  rsp_value_ff    <= '0;
                  rsp_fid_ff      <= '0;
                  state_ff        <= B_IDLE;
               end else if (is_full) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_status_ff   <= hgbfs_pkg::STAT_FULL;
                  rsp_bucket_ff   <= hgbfs_pkg::RB_W'(cmd_ff.bucket);
                  rsp_occupied_ff <= 1'b1;
                  rsp_key_ff      <= (coll_ff == '0) ? key : home_key_ff;
                  rsp_value_ff    <= '0;
                  rsp_fid_ff      <= '0;
                  state_ff        <= B_IDLE;
               end else begin
                  coll_ff  <= coll_in;
                  b_ff     <= b_in;
                  state_ff <= B_LOOK;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   `HGBFS_ASSERT_NOW(a_coll_bound, in_check_rec, coll_ff < n_eff - 11'd1)
   `HGBFS_ASSERT_NOW(a_probe_range, in_check_rec, 32'(b_ff) < 32'(n_eff))
   `HGBFS_ASSERT_NOW(a_no_rsp_clear, state_ff == B_CLEAR, !rsp_valid_ff)
   `HGBFS_ASSERT_NEXT(a_read_rsp, in_check_read, rsp_valid_ff && (rsp_status_ff == 2'd3))

endmodule

`default_nettype wire

// File: hdl/hash_group_by_file_stats.sv
// Group-by aggregation table for file statistics, open addressing, linear probe.
// Request channel req carries record items (kind 0) and read items (kind 1);
// response channel rsp returns one result per item, in order.
// csr_we/csr_wdata write the number of buckets in use (reset 1024).
// Reset starts a clearing pass over all TABLE_DEPTH buckets of the table;
// req.ready stays low until it ends.
// A record passes through the home-bucket remainder unit and the queue; the table
// engine then reads each probed bucket (B_LOOK) and checks it (B_CHECK).
// A read skips the remainder unit. The front end takes no new request until it
// has pushed the last one into the queue; the table engine takes no new item
// until it has answered the last and its output register is free or being taken.
// A result waits in the output register while rsp.ready is low; the engine
// stops there and the queue then fills and holds req.ready low.
// Depends on hgbfs_pkg, hgbfs_if, hgbfs_front, hgbfs_queue, hgbfs_back.
`default_nettype none

module hash_group_by_file_stats #(
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   hgbfs_req_if.sink                        req,
   hgbfs_rsp_if.source                      rsp,
   input  wire logic                        csr_we,
   input  wire logic [hgbfs_pkg::TU_W-1:0]  csr_wdata
);

   logic [hgbfs_pkg::TU_W-1:0]   table_used_ff;
   hgbfs_pkg::back_status_type   back_status;
   logic                         push_valid;
   logic                         push_ready;
   hgbfs_pkg::cmd_type           push_data;
   logic                         q_valid;
   logic                         q_ready;
   hgbfs_pkg::cmd_type           q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_used_ff <= hgbfs_pkg::TU_RESET;
      end else if (csr_we) begin
         table_used_ff <= csr_wdata;
      end
   end

   hgbfs_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .table_used  (table_used_ff),
      .back_status (back_status),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   hgbfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   hgbfs_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .table_used  (table_used_ff),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_data      (q_data),
      .back_status (back_status),
      .rsp         (rsp)
   );

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for hash_group_by_file_stats, the group-by table.
// Drives records and reads; expects local table model results or directed ones.
// Depends on hgbfs_pkg, hgbfs_if and the block's RTL.
`timescale 1ns / 100ps

module testbench;

   typedef struct {
      bit                          is_cfg;
      logic [hgbfs_pkg::TU_W-1:0]  cfg_value;
      logic                        kind;
      logic [31:0]                 type_key;
      logic [31:0]                 file_id;
      logic [47:0]                 file_size;
      logic [39:0]                 block_count;
      logic [39:0]                 change_time;
      logic [39:0]                 modify_time;
      logic [9:0]                  read_bucket;
      logic [3:0]                  stat_select;
      bit                          typed;
   } file_op_type;

   typedef struct {
      logic [1:0]  status;
      logic [9:0]  bucket;
      logic        occupied;
      logic [31:0] entry_key;
      logic [63:0] stat_value;
      logic [31:0] stat_file_id;
   } group_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [hgbfs_pkg::TU_W-1:0] csr_wdata = '0;
   bit quiet = 1'b0;
   int mismatches = 0;

   hgbfs_req_if req_ch ();
   hgbfs_rsp_if rsp_ch ();

   hash_group_by_file_stats #(.TABLE_DEPTH(1024)) uut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // predicted table contents
   logic [hgbfs_pkg::TU_W-1:0] buckets_cfg = hgbfs_pkg::TU_RESET;
   bit          grp_occ [1024];
   logic [31:0] grp_key [1024];
   logic [31:0] grp_count [1024];
   logic [63:0] grp_sums [1024][4];
   logic [47:0] grp_ext [1024][8];
   logic [31:0] grp_ext_id [1024][8];

   group_rsp_type expected_rsps[$];
   file_op_type directed_ops[$];
   group_rsp_type directed_rsps[$];

   always #5 clock = ~clock;

   function automatic int unsigned active_buckets();
      if (buckets_cfg < 2) return 2;
      if (buckets_cfg > 1024) return 1024;
      return buckets_cfg;
   endfunction

   function automatic group_rsp_type tally(input file_op_type op);
      group_rsp_type r;
      int unsigned n, home, b, coll;
      bit full;
      logic [47:0] v [8];
      bit take;
      r = '{default: '0};
      if (op.kind == hgbfs_pkg::KIND_RECORD) begin
         n = active_buckets();
         home = op.type_key % n;
         b = home;
         coll = 0;
         full = 0;
         v = '{48'(op.change_time), 48'(op.change_time), 48'(op.modify_time),
               48'(op.modify_time), op.file_size, op.file_size,
               48'(op.block_count), 48'(op.block_count)};
         while (grp_occ[b] && grp_key[b] != op.type_key) begin
            b = (b + 1 < n) ? b + 1 : 0;
            coll++;
            if (coll == n - 1) begin
               full = 1;
               break;
            end
         end
         if (full) begin
            r.status = hgbfs_pkg::STAT_FULL;
            b = home;
            r.occupied = grp_occ[b];
            r.entry_key = grp_occ[b] ? grp_key[b] : '0;
         end else if (!grp_occ[b]) begin
            r.status = hgbfs_pkg::STAT_NEW;
            grp_occ[b] = 1;
            grp_key[b] = op.type_key;
            grp_count[b] = 1;
            grp_sums[b] = '{64'(op.file_size), 64'(op.block_count),
                            64'(op.change_time), 64'(op.modify_time)};
            for (int i = 0; i < 8; i++) begin
               grp_ext[b][i] = v[i];
               grp_ext_id[b][i] = op.file_id;
            end
            r.occupied = 1;
            r.entry_key = op.type_key;
         end else begin
            r.status = hgbfs_pkg::STAT_UPD;
            if (grp_count[b] != '1) grp_count[b]++;
            grp_sums[b][0] += 64'(op.file_size);
            grp_sums[b][1] += 64'(op.block_count);
            grp_sums[b][2] += 64'(op.change_time);
            grp_sums[b][3] += 64'(op.modify_time);
            for (int i = 0; i < 8; i++) begin
               take = (i % 2 == 0) ? (v[i] < grp_ext[b][i]) : (v[i] > grp_ext[b][i]);
               if (take) begin
                  grp_ext[b][i] = v[i];
                  grp_ext_id[b][i] = op.file_id;
               end
            end
            r.occupied = 1;
            r.entry_key = op.type_key;
         end
      end else begin
         r.status = hgbfs_pkg::STAT_READ;
         b = op.read_bucket;
         if (grp_occ[b]) begin
            r.occupied = 1;
            r.entry_key = grp_key[b];
            if (op.stat_select == hgbfs_pkg::SEL_COUNT) begin
               r.stat_value = 64'(grp_count[b]);
            end else if (op.stat_select <= hgbfs_pkg::SEL_SUM_LAST) begin
               r.stat_value = grp_sums[b][op.stat_select - hgbfs_pkg::SEL_SUM_FIRST];
            end else if (op.stat_select <= hgbfs_pkg::SEL_EXT_LAST) begin
               r.stat_value = 64'(grp_ext[b][op.stat_select - hgbfs_pkg::SEL_EXT_FIRST]);
               r.stat_file_id = grp_ext_id[b][op.stat_select - hgbfs_pkg::SEL_EXT_FIRST];
            end
         end
      end
      r.bucket = b[9:0];
      return r;
   endfunction

   function automatic file_op_type record(input logic [31:0] key, input logic [31:0] id,
                                          input logic [47:0] size, input logic [39:0] blk,
                                          input logic [39:0] ct, input logic [39:0] mt);
      file_op_type op;
      op = '{default: '0};
      op.kind = hgbfs_pkg::KIND_RECORD;
      op.type_key = key;
      op.file_id = id;
      op.file_size = size;
      op.block_count = blk;
      op.change_time = ct;
      op.modify_time = mt;
      op.read_bucket = 10'($urandom);
      op.stat_select = 4'($urandom);
      return op;
   endfunction

   function automatic file_op_type lookup(input logic [9:0] b, input logic [3:0] sel);
      file_op_type op;
      op = record($urandom, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
      op.kind = hgbfs_pkg::KIND_READ;
      op.read_bucket = b;
      op.stat_select = sel;
      return op;
   endfunction

   function automatic file_op_type set_buckets(input logic [hgbfs_pkg::TU_W-1:0] value);
      file_op_type op;
      op = '{default: '0};
      op.is_cfg = 1;
      op.cfg_value = value;
      return op;
   endfunction

   task automatic add_typed(input file_op_type op, input logic [1:0] st,
                            input logic [9:0] b, input logic occ, input logic [31:0] key,
                            input logic [63:0] val, input logic [31:0] fid);
      op.typed = 1;
      directed_ops.push_back(op);
      directed_rsps.push_back('{st, b, occ, key, val, fid});
   endtask

   function automatic logic [63:0] pick(input int w);
      logic [63:0] mask;
      int r;
      mask = (w == 64) ? '1 : ((64'd1 << w) - 1);
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return mask;
      return {$urandom, $urandom} & mask;
   endfunction

   task automatic wait_idle();
      int guard;
      guard = 0;
      while (expected_rsps.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic write_buckets(input logic [hgbfs_pkg::TU_W-1:0] value);
      req_ch.valid <= 1'b0;
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      buckets_cfg = value;
      @(posedge clock);
   endtask

   task automatic send(input file_op_type op);
      group_rsp_type r;
      if (!quiet && $urandom_range(0, 99) < 7) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 50);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= op.kind;
      req_ch.type_key <= op.type_key;
      req_ch.file_id <= op.file_id;
      req_ch.file_size <= op.file_size;
      req_ch.block_count <= op.block_count;
      req_ch.change_time <= op.change_time;
      req_ch.modify_time <= op.modify_time;
      req_ch.read_bucket <= op.read_bucket;
      req_ch.stat_select <= op.stat_select;
      do @(posedge clock); while (!req_ch.ready);
      r = tally(op);
      if (op.typed) r = directed_rsps.pop_front();
      expected_rsps.push_back(r);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.kind = hgbfs_pkg::KIND_RECORD;
      req_ch.type_key = '0;
      req_ch.file_id = '0;
      req_ch.file_size = '0;
      req_ch.block_count = '0;
      req_ch.change_time = '0;
      req_ch.modify_time = '0;
      req_ch.read_bucket = '0;
      req_ch.stat_select = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 7);
   end

   always @(posedge clock) begin
      group_rsp_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer status=%0d bucket=%0d",
                                           rsp_ch.status, rsp_ch.bucket);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_ch.status !== e.status || rsp_ch.bucket !== e.bucket ||
                rsp_ch.occupied !== e.occupied || rsp_ch.entry_key !== e.entry_key ||
                rsp_ch.stat_value !== e.stat_value ||
                rsp_ch.stat_file_id !== e.stat_file_id) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch exp st=%0d b=%0d occ=%0d key=%h val=%h id=%h",
                           e.status, e.bucket, e.occupied, e.entry_key, e.stat_value,
                           e.stat_file_id);
                  $display("         got st=%0d b=%0d occ=%0d key=%h val=%h id=%h",
                           rsp_ch.status, rsp_ch.bucket, rsp_ch.occupied,
                           rsp_ch.entry_key, rsp_ch.stat_value, rsp_ch.stat_file_id);
               end
            end
         end
      end
   end

   initial begin
      logic [hgbfs_pkg::TU_W-1:0] phase_cfg [8];
      logic [31:0] key_pool [24];
      file_op_type op;
      int unsigned n;
      int r;
      phase_cfg = '{11'd2, 11'd0, 11'd7, 11'd2047, 11'd64, 11'd1, 11'd300, 11'd1024};

      // default table size; extremes, ties, free bucket, unused selectors
      add_typed(record('0, '1, '1, '1, '1, '1), hgbfs_pkg::STAT_NEW, 0, 1, 0, 0, 0);
      add_typed(lookup(0, hgbfs_pkg::SEL_COUNT), hgbfs_pkg::STAT_READ, 0, 1, 0, 1, 0);
      add_typed(lookup(0, 4'd10), hgbfs_pkg::STAT_READ, 0, 1, 0, 64'hFFFF_FFFF_FFFF, '1);
      add_typed(record('0, 5, 0, 0, 0, 0), hgbfs_pkg::STAT_UPD, 0, 1, 0, 0, 0);
      add_typed(lookup(0, 4'd5), hgbfs_pkg::STAT_READ, 0, 1, 0, 0, 5);
      add_typed(lookup(0, 4'd6), hgbfs_pkg::STAT_READ, 0, 1, 0, 64'hFF_FFFF_FFFF, '1);
      add_typed(record('0, 9, '1, '1, '1, '1), hgbfs_pkg::STAT_UPD, 0, 1, 0, 0, 0);
      add_typed(lookup(0, 4'd6), hgbfs_pkg::STAT_READ, 0, 1, 0, 64'hFF_FFFF_FFFF, '1);
      add_typed(lookup(0, 4'd1), hgbfs_pkg::STAT_READ, 0, 1, 0, 64'h1_FFFF_FFFF_FFFE, 0);
      add_typed(lookup(0, 4'd13), hgbfs_pkg::STAT_READ, 0, 1, 0, 0, 0);
      add_typed(lookup(0, 4'd15), hgbfs_pkg::STAT_READ, 0, 1, 0, 0, 0);
      add_typed(lookup(10'd1023, 4'd0), hgbfs_pkg::STAT_READ, 1023, 0, 0, 0, 0);
      add_typed(record('1, 7, 3, 4, 5, 6), hgbfs_pkg::STAT_NEW, 1023, 1, '1, 0, 0);
      add_typed(record(1024, 8, 100, 200, 300, 400), hgbfs_pkg::STAT_NEW, 1, 1, 1024, 0, 0);
      for (int s = 2; s <= 12; s++) directed_ops.push_back(lookup(1, 4'(s)));
      // two buckets: probe gives up before the last bucket
      directed_ops.push_back(set_buckets(11'd2));
      add_typed(record(3, 1, 1, 1, 1, 1), hgbfs_pkg::STAT_FULL, 1, 1, 1024, 0, 0);
      add_typed(record(1024, 1, 1, 1, 1, 1), hgbfs_pkg::STAT_FULL, 0, 1, 0, 0, 0);
      directed_ops.push_back(set_buckets(11'd0));
      add_typed(record(0, 2, 2, 2, 2, 2), hgbfs_pkg::STAT_UPD, 0, 1, 0, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_ops[i]) begin
         if (directed_ops[i].is_cfg) write_buckets(directed_ops[i].cfg_value);
         else send(directed_ops[i]);
      end

      foreach (phase_cfg[p]) begin
         write_buckets(phase_cfg[p]);
         quiet = (p == 4);
         n = active_buckets();
         foreach (key_pool[k]) key_pool[k] = (k < 12) ? $urandom_range(0, n + 5) : $urandom;
         for (int i = 0; i < 172; i++) begin
            if ($urandom_range(0, 99) < 60) begin
               r = $urandom_range(0, 9);
               op = record(r < 5 ? key_pool[$urandom_range(0, 23)] :
                           r < 8 ? $urandom_range(0, 2 * n) : $urandom,
                           $urandom, pick(48), pick(40), pick(40), pick(40));
            end else begin
               op = lookup($urandom_range(0, 99) < 70 ? 10'($urandom_range(0, n - 1))
                                                      : 10'($urandom),
                           4'($urandom_range(0, 15)));
            end
            send(op);
         end
      end
      req_ch.valid <= 1'b0;
      wait_idle();
      quiet = 0;
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
